// ===== hdl/clas_pkg.sv =====
package clas_pkg;

  // line parser modes
  typedef enum logic [2:0] {
    M_START   = 3'd0,
    M_PNAME_Q = 3'd1,
    M_PNAME_U = 3'd2,
    M_BETWEEN = 3'd3,
    M_ARG     = 3'd4
  } mode_t;

  // result kinds
  typedef enum logic [1:0] {
    K_RUN     = 2'd0,
    K_ENDARG  = 2'd1,
    K_ENDLINE = 2'd2
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // most results one byte can cause
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] len;
    logic        pn;
    logic [15:0] cnt;
  } res_t;

  // parser flags carried between bytes
  typedef struct packed {
    mode_t mode;
    logic  inq;
    logic  qp;
  } pstate_t;

endpackage

// ===== hdl/clas_if.sv =====
interface clas_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface clas_out_if;
  logic                valid;
  logic                ready;
  clas_pkg::kind_t     item_kind;
  logic [7:0]          out_byte;
  logic [15:0]         run_length;
  logic                is_program_name;
  logic [15:0]         argument_count;
  logic                last_of_run;

  modport source (output valid, output item_kind, output out_byte, output run_length,
                  output is_program_name, output argument_count, output last_of_run,
                  input ready);
  modport sink (input valid, input item_kind, input out_byte, input run_length,
                input is_program_name, input argument_count, input last_of_run,
                output ready);
endinterface

// ===== hdl/command_line_argument_splitter.sv =====
// a byte goes to the input register, then its results to the result buffer
// throughput: one byte per cycle while each byte yields at most one result and
//   out_if.ready is high; a byte with k results holds the result buffer until
//   all k are taken (k is at most 3), one result per cycle while ready is high
// reset: synchronous active-low; parser returns to start of line, buffers empty
module command_line_argument_splitter #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  clas_in_if.sink   in_if,
  clas_out_if.source out_if
);
  import clas_pkg::*;

  // input register
  logic                   in_v_r;
  logic [7:0]             in_byte_r;

  // parser state
  pstate_t                st_r;
  logic [COUNT_WIDTH-1:0] bs_r;
  logic [COUNT_WIDTH-1:0] args_r;

  // result buffer, head at entry 0
  res_t                   res_r [MAX_RES];
  logic [1:0]             cnt_r;

  pstate_t                st_nxt;
  logic [COUNT_WIDTH-1:0] bs_nxt;
  logic [COUNT_WIDTH-1:0] args_nxt;
  res_t                   step_res [MAX_RES];
  logic [1:0]             step_n;

  logic                   pop;
  logic                   buf_free;
  logic                   load;
  logic                   in_take;

  clas_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
    .byte_i (in_byte_r),
    .st_i   (st_r),
    .bs_i   (bs_r),
    .args_i (args_r),
    .st_o   (st_nxt),
    .bs_o   (bs_nxt),
    .args_o (args_nxt),
    .res_o  (step_res),
    .n_o    (step_n)
  );

  // handshake
  assign pop      = out_if.valid && out_if.ready;
  assign buf_free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_if.ready);
  assign load     = in_v_r && buf_free;
  assign in_if.ready = !in_v_r || buf_free;
  assign in_take  = in_if.valid && in_if.ready;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (load) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_if.text_byte;
    end
  end

  // parser state advances as a byte moves into the result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode <= M_START;
      st_r.inq  <= 1'b0;
      st_r.qp   <= 1'b0;
      bs_r      <= '0;
      args_r    <= '0;
    end else if (load) begin
      st_r   <= st_nxt;
      bs_r   <= bs_nxt;
      args_r <= args_nxt;
    end
  end

  // result buffer count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= step_n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // result buffer payload: load whole list or shift toward the head
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= step_res;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i + 1];
      end
    end
  end

  // output transaction
  assign out_if.valid           = (cnt_r != 2'd0);
  assign out_if.item_kind       = res_r[0].kind;
  assign out_if.out_byte        = res_r[0].data;
  assign out_if.run_length      = res_r[0].len;
  assign out_if.is_program_name = res_r[0].pn;
  assign out_if.argument_count  = res_r[0].cnt;
  assign out_if.last_of_run     = (cnt_r == 2'd1);

  // end of line is always the final result of its byte
  a_endline_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.item_kind == K_ENDLINE) |-> out_if.last_of_run)
    else $error("end of line not last result");

  // a byte run never has zero length
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.item_kind == K_RUN) |-> (out_if.run_length != 16'd0))
    else $error("empty byte run");

  // a zero byte leaves the parser at start of line
  a_nul_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    load && (in_byte_r == CH_NUL) |=> (st_r.mode == M_START) && (args_r == '0))
    else $error("parser not rearmed after end of line");

  // the buffer only refills once it has drained
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop))
    else $error("result buffer overrun");

endmodule

// ===== hdl/clas_step.sv =====
module clas_step #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic [7:0]             byte_i,
  input  clas_pkg::pstate_t      st_i,
  input  logic [COUNT_WIDTH-1:0] bs_i,
  input  logic [COUNT_WIDTH-1:0] args_i,
  output clas_pkg::pstate_t      st_o,
  output logic [COUNT_WIDTH-1:0] bs_o,
  output logic [COUNT_WIDTH-1:0] args_o,
  output clas_pkg::res_t         res_o [clas_pkg::MAX_RES],
  output logic [1:0]             n_o
);
  import clas_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // counts wider than the output field saturate
  function automatic logic [15:0] clamp16(input logic [COUNT_WIDTH-1:0] v);
    logic [31:0] e;
    e = 32'(v);
    return (e[31:16] != 16'd0) ? 16'hFFFF : e[15:0];
  endfunction

  function automatic res_t mk(input kind_t k, input logic [7:0] d, input logic [15:0] l,
                              input logic p, input logic [15:0] c);
    res_t r;
    r.kind = k;
    r.data = d;
    r.len  = l;
    r.pn   = p;
    r.cnt  = c;
    return r;
  endfunction

  logic [7:0]             c;
  logic                   blank;
  logic                   do_arg;
  logic                   end_ln;
  pstate_t                st;
  logic [COUNT_WIDTH-1:0] bs;
  logic [COUNT_WIDTH-1:0] args;
  logic [COUNT_WIDTH-1:0] half;
  res_t                   res [MAX_RES];
  logic [1:0]             n;

  always_comb begin
    c      = byte_i;
    blank  = (c == CH_SPACE) || (c == CH_TAB);
    st     = st_i;
    bs     = bs_i;
    args   = args_i;
    half   = bs_i >> 1;
    do_arg = 1'b0;
    end_ln = 1'b0;
    n      = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end

    // mode specific handling
    case (st_i.mode)
      M_START: begin
        args = COUNT_WIDTH'(1);
        if (c == CH_QUOTE) begin
          st.mode = M_PNAME_Q;
        end else if (c == CH_NUL) begin
          res[n] = mk(K_ENDARG, 8'd0, 16'd0, 1'b1, 16'd0); n = n + 2'd1;
          end_ln = 1'b1;
        end else if (blank) begin
          res[n] = mk(K_ENDARG, 8'd0, 16'd0, 1'b1, 16'd0); n = n + 2'd1;
          st.mode = M_BETWEEN;
        end else begin
          res[n] = mk(K_RUN, c, 16'd1, 1'b1, 16'd0); n = n + 2'd1;
          st.mode = M_PNAME_U;
        end
      end
      M_PNAME_Q: begin
        if (c == CH_NUL) begin
          res[n] = mk(K_ENDARG, 8'd0, 16'd0, 1'b1, 16'd0); n = n + 2'd1;
          end_ln = 1'b1;
        end else if (c == CH_QUOTE) begin
          res[n] = mk(K_ENDARG, 8'd0, 16'd0, 1'b1, 16'd0); n = n + 2'd1;
          st.mode = M_BETWEEN;
        end else begin
          res[n] = mk(K_RUN, c, 16'd1, 1'b1, 16'd0); n = n + 2'd1;
        end
      end
      M_PNAME_U: begin
        if (c == CH_NUL) begin
          res[n] = mk(K_ENDARG, 8'd0, 16'd0, 1'b1, 16'd0); n = n + 2'd1;
          end_ln = 1'b1;
        end else if (blank) begin
          res[n] = mk(K_ENDARG, 8'd0, 16'd0, 1'b1, 16'd0); n = n + 2'd1;
          st.mode = M_BETWEEN;
        end else begin
          res[n] = mk(K_RUN, c, 16'd1, 1'b1, 16'd0); n = n + 2'd1;
        end
      end
      M_BETWEEN: begin
        if (c == CH_NUL) begin
          end_ln = 1'b1;
        end else if (!blank) begin
          if (args != CNT_MAX) begin
            args = args + COUNT_WIDTH'(1);
          end
          st.mode = M_ARG;
          st.inq  = 1'b0;
          st.qp   = 1'b0;
          bs      = '0;
          do_arg  = 1'b1;
        end
      end
      M_ARG: begin
        if (bs_i != '0) begin
          // held backslashes resolve on the first other byte
          if (c == CH_BSL) begin
            if (bs_i != CNT_MAX) begin
              bs = bs_i + COUNT_WIDTH'(1);
            end
          end else begin
            bs = '0;
            if (c == CH_QUOTE) begin
              if (half != '0) begin
                res[n] = mk(K_RUN, CH_BSL, clamp16(half), 1'b0, 16'd0); n = n + 2'd1;
              end
              if (bs_i[0]) begin
                res[n] = mk(K_RUN, CH_QUOTE, 16'd1, 1'b0, 16'd0); n = n + 2'd1;
              end else begin
                do_arg = 1'b1;
              end
            end else begin
              res[n] = mk(K_RUN, CH_BSL, clamp16(bs_i), 1'b0, 16'd0); n = n + 2'd1;
              do_arg = 1'b1;
            end
          end
        end else if (st_i.qp) begin
          // doubled quote inside quotes is a literal quote
          st.qp = 1'b0;
          if (c == CH_QUOTE) begin
            res[n] = mk(K_RUN, CH_QUOTE, 16'd1, 1'b0, 16'd0); n = n + 2'd1;
          end else begin
            st.inq = 1'b0;
            do_arg = 1'b1;
          end
        end else begin
          do_arg = 1'b1;
        end
      end
      default: begin
        st.mode = M_START;
        st.inq  = 1'b0;
        st.qp   = 1'b0;
        bs      = '0;
        args    = '0;
      end
    endcase

    // plain byte inside an argument
    if (do_arg) begin
      if (c == CH_NUL) begin
        res[n] = mk(K_ENDARG, 8'd0, 16'd0, 1'b0, 16'd0); n = n + 2'd1;
        end_ln = 1'b1;
      end else if (!st.inq && blank) begin
        res[n] = mk(K_ENDARG, 8'd0, 16'd0, 1'b0, 16'd0); n = n + 2'd1;
        st.mode = M_BETWEEN;
      end else if (c == CH_QUOTE) begin
        if (st.inq) begin
          st.qp = 1'b1;
        end else begin
          st.inq = 1'b1;
        end
      end else if (c == CH_BSL) begin
        bs = COUNT_WIDTH'(1);
      end else begin
        res[n] = mk(K_RUN, c, 16'd1, 1'b0, 16'd0); n = n + 2'd1;
      end
    end

    // end of line: report count and rearm for the next line
    if (end_ln) begin
      res[n] = mk(K_ENDLINE, 8'd0, 16'd0, 1'b0, clamp16(args)); n = n + 2'd1;
      st.mode = M_START;
      st.inq  = 1'b0;
      st.qp   = 1'b0;
      bs      = '0;
      args    = '0;
    end

    st_o   = st;
    bs_o   = bs;
    args_o = args;
    res_o  = res;
    n_o    = n;
  end

endmodule

// ===== tb/command_line_argument_splitter_tb.sv =====
`timescale 1ns / 1ps

module command_line_argument_splitter_tb;
  import clas_pkg::*;

  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  logic clk;
  logic rst_n;

  clas_in_if  in_ch ();
  clas_out_if out_ch ();

  command_line_argument_splitter #(
    .COUNT_WIDTH(CNT_W)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // one expected result and whether it closes its byte
  typedef struct packed {
    res_t res;
    logic last_flag;
  } token_t;

  token_t      token_q[$];
  res_t        byte_res[$];
  int unsigned mismatch_count;
  int unsigned bytes_accepted;
  int unsigned burst_left;
  bit          sender_idle_en;
  bit          stall_en;
  logic [15:0] ready_pat;
  int unsigned pat_left;

  // parser state mirrored by the predictor
  mode_t            pmode;
  logic             in_quotes;
  logic             quote_wait;
  logic [CNT_W-1:0] bs_run;
  logic [CNT_W-1:0] arg_total;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // argument splitting predictor
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] sat16(logic [CNT_W-1:0] v);
    longint unsigned wide;
    wide = 64'(v);
    return (wide > 64'hFFFF) ? 16'hFFFF : 16'(wide);
  endfunction

  function automatic void put_token(kind_t k, logic [7:0] d, logic [15:0] n, logic p,
                                    logic [15:0] c);
    res_t r;
    r.kind = k;
    r.data = d;
    r.len  = n;
    r.pn   = p;
    r.cnt  = c;
    byte_res.push_back(r);
  endfunction

  function automatic void reset_parser();
    pmode      = M_START;
    in_quotes  = 1'b0;
    quote_wait = 1'b0;
    bs_run     = '0;
    arg_total  = '0;
  endfunction

  function automatic void close_line();
    put_token(K_ENDLINE, 8'h00, 16'd0, 1'b0, sat16(arg_total));
    reset_parser();
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // byte inside an argument with nothing held back
  function automatic void arg_char(logic [7:0] c);
    if (c == CH_NUL) begin
      put_token(K_ENDARG, 8'h00, 16'd0, 1'b0, 16'd0);
      close_line();
    end else if (!in_quotes && is_blank(c)) begin
      put_token(K_ENDARG, 8'h00, 16'd0, 1'b0, 16'd0);
      pmode = M_BETWEEN;
    end else if (c == CH_QUOTE) begin
      if (in_quotes) quote_wait = 1'b1;
      else in_quotes = 1'b1;
    end else if (c == CH_BSL) begin
      bs_run = CNT_W'(1);
    end else begin
      put_token(K_RUN, c, 16'd1, 1'b0, 16'd0);
    end
  endfunction

  // work out the results of one accepted byte and queue them
  function automatic void split_byte(logic [7:0] c);
    logic [CNT_W-1:0] held;
    byte_res.delete();
    case (pmode)
      M_START: begin
        arg_total = CNT_W'(1);
        if (c == CH_QUOTE) begin
          pmode = M_PNAME_Q;
        end else if (c == CH_NUL) begin
          put_token(K_ENDARG, 8'h00, 16'd0, 1'b1, 16'd0);
          close_line();
        end else if (is_blank(c)) begin
          put_token(K_ENDARG, 8'h00, 16'd0, 1'b1, 16'd0);
          pmode = M_BETWEEN;
        end else begin
          put_token(K_RUN, c, 16'd1, 1'b1, 16'd0);
          pmode = M_PNAME_U;
        end
      end
      M_PNAME_Q, M_PNAME_U: begin
        if (c == CH_NUL) begin
          put_token(K_ENDARG, 8'h00, 16'd0, 1'b1, 16'd0);
          close_line();
        end else if ((pmode == M_PNAME_Q) ? (c == CH_QUOTE) : is_blank(c)) begin
          put_token(K_ENDARG, 8'h00, 16'd0, 1'b1, 16'd0);
          pmode = M_BETWEEN;
        end else begin
          put_token(K_RUN, c, 16'd1, 1'b1, 16'd0);
        end
      end
      M_BETWEEN: begin
        if (c == CH_NUL) begin
          close_line();
        end else if (!is_blank(c)) begin
          if (arg_total != CNT_SAT) arg_total++;
          pmode      = M_ARG;
          in_quotes  = 1'b0;
          quote_wait = 1'b0;
          bs_run     = '0;
          arg_char(c);
        end
      end
      M_ARG: begin
        if (bs_run != 0) begin
          if (c == CH_BSL) begin
            if (bs_run != CNT_SAT) bs_run++;
          end else begin
            held   = bs_run;
            bs_run = '0;
            if (c == CH_QUOTE) begin
              // run halves; even leaves the quote active, odd adds a literal quote
              if ((held >> 1) != 0) put_token(K_RUN, CH_BSL, sat16(held >> 1), 1'b0, 16'd0);
              if (held[0]) put_token(K_RUN, CH_QUOTE, 16'd1, 1'b0, 16'd0);
              else arg_char(c);
            end else begin
              put_token(K_RUN, CH_BSL, sat16(held), 1'b0, 16'd0);
              arg_char(c);
            end
          end
        end else if (quote_wait) begin
          quote_wait = 1'b0;
          if (c == CH_QUOTE) begin
            put_token(K_RUN, CH_QUOTE, 16'd1, 1'b0, 16'd0);
          end else begin
            in_quotes = 1'b0;
            arg_char(c);
          end
        end else begin
          arg_char(c);
        end
      end
      default: reset_parser();
    endcase
    foreach (byte_res[i]) token_q.push_back('{res: byte_res[i],
                                              last_flag: (i == byte_res.size() - 1)});
  endfunction

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    // bursts of random length separated by random gaps
    if (sender_idle_en) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    split_byte(b);
    bytes_accepted++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_NUL);
  endtask

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  // one argument built from letters, backslash runs, quotes and raw bytes
  task automatic send_random_arg();
    int unsigned pieces;
    pieces = $urandom_range(1, 4);
    repeat (pieces) begin
      case ($urandom_range(0, 5))
        0, 1: send_byte(8'($urandom_range(8'h61, 8'h7A)));
        2: begin
          repeat ($urandom_range(1, 5)) send_byte(CH_BSL);
          if ($urandom_range(0, 1)) send_byte(CH_QUOTE);
        end
        3: send_byte(CH_QUOTE);
        4: begin
          send_byte(CH_QUOTE);
          send_byte(CH_QUOTE);
        end
        default: send_byte(8'($urandom_range(1, 255)));
      endcase
    end
  endtask

  // random line: program name, up to four arguments, terminator
  task automatic send_random_line();
    if ($urandom_range(0, 2) == 0) begin
      send_byte(CH_QUOTE);
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 7) != 0) send_byte(CH_QUOTE);
    end else begin
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(1, 255)));
    end
    repeat ($urandom_range(0, 4)) begin
      repeat ($urandom_range(1, 2)) send_byte(pick_blank());
      send_random_arg();
    end
    if ($urandom_range(0, 3) == 0) send_byte(pick_blank());
    send_byte(CH_NUL);
  endtask

  // noise rich in special bytes, stray terminators included
  task automatic send_noise_line();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 5))
        0: send_byte(CH_NUL);
        1: send_byte(CH_QUOTE);
        2: send_byte(CH_BSL);
        3: send_byte(pick_blank());
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    send_byte(CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // receiver and checker
  // ---------------------------------------------------------------------------

  function automatic void report_mismatch(string what, token_t want, token_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected kind %0d byte %02h len %0d pn %0b cnt %0d last %0b", what,
               want.res.kind, want.res.data, want.res.len, want.res.pn, want.res.cnt,
               want.last_flag);
      $display("  actual kind %0d byte %02h len %0d pn %0b cnt %0d last %0b",
               got.res.kind, got.res.data, got.res.len, got.res.pn, got.res.cnt,
               got.last_flag);
    end
  endfunction

  function automatic void check_token();
    token_t got;
    token_t want;
    got.res.kind  = out_ch.item_kind;
    got.res.data  = out_ch.out_byte;
    got.res.len   = out_ch.run_length;
    got.res.pn    = out_ch.is_program_name;
    got.res.cnt   = out_ch.argument_count;
    got.last_flag = out_ch.last_of_run;
    if (token_q.size() == 0) begin
      report_mismatch("unexpected transaction", '0, got);
    end else begin
      want = token_q.pop_front();
      if ((got.res.kind !== want.res.kind) || (got.res.data !== want.res.data) ||
          (got.res.len !== want.res.len) || (got.res.pn !== want.res.pn) ||
          (got.res.cnt !== want.res.cnt) || (got.last_flag !== want.last_flag))
        report_mismatch("field mismatch", want, got);
    end
  endfunction

  // check each transaction, then drive ready high or from a rotating stall pattern
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) check_token();
    if (!stall_en) begin
      out_ch.ready <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        pat_left  = $urandom_range(16, 80);
      end
      pat_left--;
      out_ch.ready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed_lines();
    sender_idle_en = 1'b1;
    stall_en       = 1'b1;
    // empty line, then a blank one
    send_text("");
    send_text(" \t");
    // quoted name with literal backslash and space, text glued after it,
    // doubled quote inside quotes, line ending inside quotes
    send_text("\"\\ \"x\t\"y\"\"z");
    // unquoted name with literals, odd and even backslash runs before a quote,
    // quote still pending then a backslash held at the line end
    send_text("p\\\"q a\\\\\\\"b\\\\\"c d\"\\");
    // unterminated quoted name with all bits set
    send_byte(CH_QUOTE);
    send_byte(8'hFF);
    send_byte(CH_NUL);
  endtask

  task automatic test_random_lines();
    int unsigned start;
    start = bytes_accepted;
    while (bytes_accepted - start < 240) begin
      sender_idle_en = ($urandom_range(0, 3) != 0);
      stall_en       = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) send_noise_line();
      else send_random_line();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_parser();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.text_byte <= 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_lines();
    test_random_lines();

    in_ch.valid <= 1'b0;
    stall_en = 1'b1;
    while (token_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
